>>> rtl/snc_pkg.sv
// Package for the symbol name cache: sizes, count limits, the entry word,
// the controller states and the command and status structs.
// Depends on nothing; the controller, datapath, top level and testbench import it.
package snc_pkg;

   localparam int ENTRIES    = 50;
   localparam int KEY_BITS   = 16;
   localparam int NAME_BITS  = 32;
   localparam int COUNT_BITS = 15;
   localparam int SLOT_BITS  = 6;
   localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   localparam logic [IDX_BITS-1:0]   LAST_IDX    = IDX_BITS'(ENTRIES - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_CEIL  = COUNT_BITS'(30000);
   localparam logic [COUNT_BITS-1:0] COUNT_FLOOR = COUNT_BITS'(10000);
   localparam logic [COUNT_BITS-1:0] COUNT_FIRST = COUNT_BITS'(1);

   typedef struct packed {
      logic [KEY_BITS-1:0]   key;
      logic [NAME_BITS-1:0]  name;
      logic [COUNT_BITS-1:0] count;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic hit_found;
      logic scan_done;
   } dp_status_type;

endpackage

>>> rtl/snc_ctrl.sv
// Controller of the symbol name cache: accepts a request word, runs the
// entry scan for a present symbol and triggers the update and result. Depends on snc_pkg.
module snc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  present,
   input  snc_pkg::dp_status_type status,
   output snc_pkg::ctl_cmd_type  cmd,
   output logic                  busy
);
   import snc_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = present ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.hit_found || status.scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/snc_datapath.sv
// Datapath of the symbol name cache: entry memory, valid bits, the scan
// pipeline with match and smallest-count search, and the result register.
// Depends on snc_pkg.
module snc_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  snc_pkg::ctl_cmd_type          cmd,
   output snc_pkg::dp_status_type        status,
   input  logic                          req_op,
   input  logic                          req_symbol_present,
   input  logic [15:0]                   req_symbol_key,
   input  logic [31:0]                   req_name_in,
   output logic                          rsp_valid,
   output logic                          rsp_null_symbol,
   output logic                          rsp_hit,
   output logic                          rsp_filled,
   output logic [5:0]                    rsp_slot,
   output logic [31:0]                   rsp_name_out
);
   import snc_pkg::*;

   entry_type mem [ENTRIES];
   entry_type rdata_ff;
   entry_type wr_data;

   logic [ENTRIES-1:0]    valid_ff;
   logic                  op_ff;
   logic                  present_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [NAME_BITS-1:0]  name_ff;

   logic [IDX_BITS-1:0]   rd_idx_ff, rd_idx_in;
   logic                  rd_done_ff, rd_done_in;
   logic [IDX_BITS-1:0]   cmp_idx_ff, cmp_idx_in;
   logic                  cmp_vld_ff, cmp_vld_in;
   logic                  hit_ff, hit_in;
   logic [IDX_BITS-1:0]   hit_slot_ff, hit_slot_in;
   logic [NAME_BITS-1:0]  hit_name_ff, hit_name_in;
   logic [COUNT_BITS-1:0] hit_cnt_ff, hit_cnt_in;
   logic [COUNT_BITS-1:0] best_ff, best_in;
   logic [IDX_BITS-1:0]   victim_ff, victim_in;

   logic                  issue;
   logic                  cmp_entry_valid;
   logic                  match;
   logic [COUNT_BITS-1:0] eff_count;
   logic [COUNT_BITS-1:0] cnt_inc;
   logic [COUNT_BITS-1:0] cnt_new;
   logic                  wr_en;
   logic [IDX_BITS-1:0]   wr_idx;

   assign issue           = cmd.scan && !rd_done_ff;
   assign cmp_entry_valid = valid_ff[cmp_idx_ff];
   assign match           = cmp_vld_ff && cmp_entry_valid && (rdata_ff.key == key_ff);
   assign eff_count       = cmp_entry_valid ? rdata_ff.count : '0;

   assign status.hit_found = cmd.scan && match;
   assign status.scan_done = cmd.scan && cmp_vld_ff && (cmp_idx_ff == LAST_IDX);

   assign cnt_inc = hit_cnt_ff + COUNT_FIRST;
   assign cnt_new = (cnt_inc >= COUNT_CEIL) ? COUNT_FLOOR : cnt_inc;

   assign wr_en  = cmd.finish && present_ff && (hit_ff || !op_ff);
   assign wr_idx = hit_ff ? hit_slot_ff : victim_ff;

   always_comb begin
      if (hit_ff) begin
         wr_data = '{key: key_ff, name: hit_name_ff, count: cnt_new};
      end else begin
         wr_data = '{key: key_ff, name: name_ff, count: COUNT_FIRST};
      end
   end

   always_comb begin
      rd_idx_in   = rd_idx_ff;
      rd_done_in  = rd_done_ff;
      cmp_idx_in  = cmp_idx_ff;
      cmp_vld_in  = cmp_vld_ff;
      hit_in      = hit_ff;
      hit_slot_in = hit_slot_ff;
      hit_name_in = hit_name_ff;
      hit_cnt_in  = hit_cnt_ff;
      best_in     = best_ff;
      victim_in   = victim_ff;
      if (cmd.load) begin
         rd_idx_in  = '0;
         rd_done_in = 1'b0;
         cmp_vld_in = 1'b0;
         hit_in     = 1'b0;
         best_in    = COUNT_CEIL;
         victim_in  = '0;
      end else if (cmd.scan) begin
         cmp_vld_in = issue;
         cmp_idx_in = rd_idx_ff;
         if (issue) begin
            if (rd_idx_ff == LAST_IDX) begin
               rd_done_in = 1'b1;
            end else begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
         end
         if (match) begin
            hit_in      = 1'b1;
            hit_slot_in = cmp_idx_ff;
            hit_name_in = rdata_ff.name;
            hit_cnt_in  = rdata_ff.count;
         end else if (cmp_vld_ff && (eff_count < best_ff)) begin
            best_in   = eff_count;
            victim_in = cmp_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rdata_ff <= mem[rd_idx_ff];
      end
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      rd_done_ff  <= rd_done_in;
      cmp_idx_ff  <= cmp_idx_in;
      cmp_vld_ff  <= cmp_vld_in;
      hit_ff      <= hit_in;
      hit_slot_ff <= hit_slot_in;
      hit_name_ff <= hit_name_in;
      hit_cnt_ff  <= hit_cnt_in;
      best_ff     <= best_in;
      victim_ff   <= victim_in;
      if (cmd.load) begin
         op_ff      <= req_op;
         present_ff <= req_symbol_present;
         key_ff     <= KEY_BITS'(req_symbol_key);
         name_ff    <= req_name_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= cmd.finish;
         if (wr_en && !hit_ff) begin
            valid_ff[victim_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_null_symbol <= 1'b0;
         rsp_hit         <= 1'b0;
         rsp_filled      <= 1'b0;
         rsp_slot        <= '0;
         rsp_name_out    <= '0;
         if (!present_ff) begin
            rsp_null_symbol <= 1'b1;
         end else if (hit_ff) begin
            rsp_hit      <= 1'b1;
            rsp_slot     <= SLOT_BITS'(hit_slot_ff);
            rsp_name_out <= hit_name_ff;
         end else begin
            rsp_name_out <= name_ff;
            if (!op_ff) begin
               rsp_filled <= 1'b1;
               rsp_slot   <= SLOT_BITS'(victim_ff);
            end
         end
      end
   end

endmodule

>>> rtl/symbol_name_cache_lfu.sv
// Top level of the symbol name cache with least-frequently-used replacement.
// Joins the controller and the datapath. Depends on snc_pkg, snc_ctrl and
// snc_datapath.
//
// A request word is accepted at a rising edge where start is high and busy
// is low. The cache reads its entries one per cycle from a single-port
// entry memory, comparing keys and tracking the first smallest use count as
// the data arrives. A hit stops the scan at the matching entry; a miss reads
// all entries. The finish state then writes the entry on a hit or a fill and
// loads the result register, and the result word is shown for one cycle with
// rsp_valid high. A null symbol skips the scan and goes straight to the
// finish state. busy drops in the cycle the strobe is shown, so a new
// request can be accepted at the end of that cycle, and not before.
// The receiver cannot stall; each result is taken in its strobe cycle.
// Reset clears the controller, the result strobe and all entry valid bits,
// so the cache starts empty with no clearing pass.
module symbol_name_cache_lfu (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic        req_symbol_present,
   input  logic [15:0] req_symbol_key,
   input  logic [31:0] req_name_in,
   output logic        rsp_valid,
   output logic        rsp_null_symbol,
   output logic        rsp_hit,
   output logic        rsp_filled,
   output logic [5:0]  rsp_slot,
   output logic [31:0] rsp_name_out
);
   import snc_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   snc_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .present (req_symbol_present),
      .status  (status),
      .cmd     (cmd),
      .busy    (busy)
   );

   snc_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_op             (req_op),
      .req_symbol_present (req_symbol_present),
      .req_symbol_key     (req_symbol_key),
      .req_name_in        (req_name_in),
      .rsp_valid          (rsp_valid),
      .rsp_null_symbol    (rsp_null_symbol),
      .rsp_hit            (rsp_hit),
      .rsp_filled         (rsp_filled),
      .rsp_slot           (rsp_slot),
      .rsp_name_out       (rsp_name_out)
   );

endmodule

>>> rtl/snc_checker.sv
// Port-level checker for the symbol name cache and its bind to the top level.
// Depends only on the top level's ports.
module snc_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_null_symbol,
   input logic        rsp_hit,
   input logic        rsp_filled,
   input logic [5:0]  rsp_slot,
   input logic [31:0] rsp_name_out
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("Accepted request did not make the block busy.");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("Result strobe lasted more than one cycle.");

   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(busy))
      else $error("Result word appeared without a request in progress.");

   a_null_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_null_symbol) |->
         (!rsp_hit && !rsp_filled && rsp_slot == 6'd0 && rsp_name_out == 32'd0))
      else $error("Null symbol result carries nonzero fields.");

   a_hit_fill_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_filled))
      else $error("Result marked as both hit and fill.");

endmodule

bind symbol_name_cache_lfu snc_checker u_snc_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_null_symbol (rsp_null_symbol),
   .rsp_hit         (rsp_hit),
   .rsp_filled      (rsp_filled),
   .rsp_slot        (rsp_slot),
   .rsp_name_out    (rsp_name_out)
);

>>> sim/symbol_name_cache_lfu_tb.sv
// Self-checking testbench for symbol_name_cache_lfu: a queue-fed driver, a result
// monitor and an in-bench LFU cache predictor that supplies the expected words.
// Depends on snc_pkg and the symbol_name_cache_lfu RTL.
`timescale 1ns / 1ps

module symbol_name_cache_lfu_tb;
   import snc_pkg::*;

   localparam logic OP_FILL = 1'b0;
   localparam logic OP_PEEK = 1'b1;
   localparam int   KEY_POOL_SIZE = 62;
   localparam int   RANDOM_WORDS = 700;
   localparam int   SLOT0_HITS = 40;
   localparam int   QUIET_TAIL = 80;
   localparam int   MAX_PRINTED = 20;

   typedef struct packed {
      logic                 op;
      logic                 present;
      logic [KEY_BITS-1:0]  key;
      logic [NAME_BITS-1:0] name;
   } cache_req_type;

   typedef struct packed {
      logic                 null_symbol;
      logic                 hit;
      logic                 filled;
      logic [SLOT_BITS-1:0] slot;
      logic [NAME_BITS-1:0] name_out;
   } lookup_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_op = 1'b0;
   logic        req_symbol_present = 1'b0;
   logic [15:0] req_symbol_key = '0;
   logic [31:0] req_name_in = '0;
   logic        rsp_valid;
   logic        rsp_null_symbol;
   logic        rsp_hit;
   logic        rsp_filled;
   logic [5:0]  rsp_slot;
   logic [31:0] rsp_name_out;

   cache_req_type     pending_reqs[$];
   lookup_result_type expected_results[$];
   cache_req_type     driven_req;

   logic                  cache_valid[ENTRIES];
   logic [KEY_BITS-1:0]   cache_key[ENTRIES];
   logic [NAME_BITS-1:0]  cache_name[ENTRIES];
   logic [COUNT_BITS-1:0] cache_count[ENTRIES];

   logic [KEY_BITS-1:0] key_pool[KEY_POOL_SIZE];

   int gap_left = 0;
   int mismatches = 0;
   int words_sent = 0;
   int words_checked = 0;
   int hits_seen = 0;
   int fills_seen = 0;
   int peek_misses = 0;
   int nulls_seen = 0;

   symbol_name_cache_lfu DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_op             (req_op),
      .req_symbol_present (req_symbol_present),
      .req_symbol_key     (req_symbol_key),
      .req_name_in        (req_name_in),
      .rsp_valid          (rsp_valid),
      .rsp_null_symbol    (rsp_null_symbol),
      .rsp_hit            (rsp_hit),
      .rsp_filled         (rsp_filled),
      .rsp_slot           (rsp_slot),
      .rsp_name_out       (rsp_name_out)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= MAX_PRINTED)
         $display("%0t ns: mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
   endtask

   function automatic lookup_result_type predict_lookup(cache_req_type r);
      lookup_result_type     res;
      logic [COUNT_BITS-1:0] least;
      logic [COUNT_BITS-1:0] bumped;
      int                    victim;
      res = '0;
      least = COUNT_CEIL;
      victim = 0;
      if (!r.present) begin
         res.null_symbol = 1'b1;
         return res;
      end
      for (int i = 0; i < ENTRIES; i++) begin
         if (cache_valid[i] && cache_key[i] == r.key) begin
            bumped = cache_count[i] + 1'b1;
            if (bumped >= COUNT_CEIL)
               bumped = COUNT_FLOOR;
            cache_count[i] = bumped;
            res.hit = 1'b1;
            res.slot = SLOT_BITS'(i);
            res.name_out = cache_name[i];
            return res;
         end
         if (cache_count[i] < least) begin
            least = cache_count[i];
            victim = i;
         end
      end
      if (r.op == OP_FILL) begin
         cache_valid[victim] = 1'b1;
         cache_key[victim] = r.key;
         cache_name[victim] = r.name;
         cache_count[victim] = COUNT_FIRST;
         res.filled = 1'b1;
         res.slot = SLOT_BITS'(victim);
      end
      res.name_out = r.name;
      return res;
   endfunction

   function automatic cache_req_type make_req(logic op, logic present, logic [15:0] key,
                                              logic [31:0] name);
      cache_req_type r;
      r.op = op;
      r.present = present;
      r.key = key;
      r.name = name;
      return r;
   endfunction

   function automatic cache_req_type random_req();
      cache_req_type r;
      r.op = ($urandom_range(0, 3) == 0) ? OP_PEEK : OP_FILL;
      r.present = ($urandom_range(0, 12) != 0);
      if ($urandom_range(0, 4) == 0)
         r.key = KEY_BITS'($urandom);
      else
         r.key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
      r.name = $urandom;
      return r;
   endfunction

   always @(posedge clock) begin : drive_words
      lookup_result_type res;
      cache_req_type     nxt;
      logic              fire;
      if (reset) begin
         start <= 1'b0;
      end else begin
         fire = start && !busy;
         if (fire) begin
            res = predict_lookup(driven_req);
            expected_results.push_back(res);
            words_sent++;
            if (res.null_symbol)
               nulls_seen++;
            else if (res.hit)
               hits_seen++;
            else if (res.filled)
               fills_seen++;
            else
               peek_misses++;
            if (pending_reqs.size() > QUIET_TAIL && $urandom_range(0, 3) == 0)
               gap_left = $urandom_range(1, 5);
         end
         if (fire || !start) begin
            if (gap_left > 0) begin
               if (!busy)
                  gap_left--;
               start <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               nxt = pending_reqs.pop_front();
               driven_req <= nxt;
               req_op <= nxt.op;
               req_symbol_present <= nxt.present;
               req_symbol_key <= nxt.key;
               req_name_in <= nxt.name;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_words
      lookup_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result word", 32'd0, 32'd1);
         end else begin
            want = expected_results.pop_front();
            words_checked++;
            if (rsp_null_symbol !== want.null_symbol)
               report_mismatch("null_symbol", want.null_symbol, rsp_null_symbol);
            if (rsp_hit !== want.hit)
               report_mismatch("hit", want.hit, rsp_hit);
            if (rsp_filled !== want.filled)
               report_mismatch("filled", want.filled, rsp_filled);
            if (rsp_slot !== want.slot)
               report_mismatch("slot", want.slot, rsp_slot);
            if (rsp_name_out !== want.name_out)
               report_mismatch("name_out", want.name_out, rsp_name_out);
         end
      end
   end

   initial begin
      #40_000_000;
      $display("symbol_name_cache_lfu test failed");
      $finish;
   end

   initial begin
      int idle_cycles;
      for (int i = 0; i < ENTRIES; i++) begin
         cache_valid[i] = 1'b0;
         cache_key[i] = '0;
         cache_name[i] = '0;
         cache_count[i] = '0;
      end
      key_pool[0] = 16'h0000;
      key_pool[1] = 16'hFFFF;
      for (int i = 2; i < KEY_POOL_SIZE; i++)
         key_pool[i] = KEY_BITS'($urandom);

      // The predictor's empty cache holds key 0 in every invalid entry, which must never match.
      pending_reqs.push_back(make_req(OP_PEEK, 1'b1, 16'h0000, 32'hFFFF_FFFF));
      pending_reqs.push_back(make_req(OP_FILL, 1'b0, 16'hFFFF, 32'hFFFF_FFFF));
      pending_reqs.push_back(make_req(OP_PEEK, 1'b0, 16'h0000, 32'h0000_0000));
      pending_reqs.push_back(make_req(OP_FILL, 1'b1, 16'h0000, 32'h0000_0000));
      // Hammer slot 0 so that its use count climbs well above the others.
      for (int i = 0; i < SLOT0_HITS; i++)
         pending_reqs.push_back(make_req(1'($urandom_range(0, 1)), 1'b1, 16'h0000,
                                         $urandom));
      pending_reqs.push_back(make_req(OP_FILL, 1'b1, 16'hFFFF, 32'hFFFF_FFFF));
      pending_reqs.push_back(make_req(OP_PEEK, 1'b1, 16'hFFFF, 32'h1234_5678));
      pending_reqs.push_back(make_req(OP_FILL, 1'b1, 16'h8000, 32'h8000_0000));
      pending_reqs.push_back(make_req(OP_FILL, 1'b1, 16'h7FFF, 32'h7FFF_FFFF));
      pending_reqs.push_back(make_req(OP_PEEK, 1'b1, 16'h5555, 32'hAAAA_5555));
      pending_reqs.push_back(make_req(OP_PEEK, 1'b1, 16'h0000, 32'h5555_AAAA));
      pending_reqs.push_back(make_req(OP_FILL, 1'b1, 16'h7FFF, 32'h0000_0001));
      pending_reqs.push_back(make_req(OP_FILL, 1'b0, 16'h8000, 32'h8000_0000));
      for (int i = 0; i < RANDOM_WORDS; i++)
         pending_reqs.push_back(random_req());

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (pending_reqs.size() > 0 || start || expected_results.size() > 0);
      idle_cycles = 0;
      while (idle_cycles < ENTRIES + 10) begin
         @(posedge clock);
         idle_cycles++;
      end

      $display("Sent %0d words and checked %0d results: %0d hits, %0d fills,",
               words_sent, words_checked, hits_seen, fills_seen);
      $display("%0d peek misses and %0d null symbols; slot 0 was hit repeatedly.",
               peek_misses, nulls_seen);
      if (mismatches == 0 && expected_results.size() == 0)
         $display("symbol_name_cache_lfu test passed");
      else
         $display("symbol_name_cache_lfu test failed");
      $finish;
   end

endmodule
